// File: rtl/spq_pkg.sv
// Shared package for the sorted priority queue.
// Holds the operation and status codes, the entry type and the default depth.
// No dependencies.
package spq_pkg;

    // Default number of entries the store can hold.
    localparam int DEPTH_DEF = 16;

    // Operation codes carried by the kind field of an input item.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    // Status codes carried by the status field of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // One stored entry: data word and priority.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } t_entry;

endpackage

// File: rtl/spq_mem.sv
// Entry store of the sorted priority queue: one write port and one read port.
// The read data is registered. Depends on spq_pkg for the entry type.
module spq_mem #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output spq_pkg::t_entry o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: sequencer, ring pointers and output register.
// Depends on spq_pkg and spq_mem.
//
// The queue holds up to DEPTH entries in a single-port-read memory organized as a ring,
// sorted by ascending priority with equal priorities in arrival order. The block takes
// one item at a time and stalls its input until that item's work is done. An insert
// walks back from the tail, moving each entry of larger priority one slot up; a full
// store or an empty store skips the walk. A remove just advances the head slot. A list
// gives its results head first. Each step makes one registered read of the entry memory,
// and stalls on the output hold the sequencer.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_item_value,
    input  logic signed [31:0] i_priority_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic signed [31:0] o_out_priority,
    output logic               o_last
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_RD   = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_INS_PUT  = 3'd3;
    localparam logic [2:0] S_RM_WAIT  = 3'd4;
    localparam logic [2:0] S_LST_RD   = 3'd5;
    localparam logic [2:0] S_LST_WAIT = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_pri, n_pri;
    logic [1:0]         r_res_status, n_res_status;
    t_entry             r_res_entry, n_res_entry;
    logic               r_res_last, n_res_last;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status, n_out_status;
    t_entry             r_out_entry, n_out_entry;
    logic               r_out_last, n_out_last;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    logic [AW-1:0]      mem_raddr;
    t_entry             mem_rdata;
    t_entry             new_entry;
    logic               in_accept;
    logic               slot_free;

    // Logical position in the ring to physical memory address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + off;
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    spq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign new_entry  = '{value: r_val, prio: r_pri};

    // Sequencer: one memory read or write per step.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_idx        = r_idx;
        n_val        = r_val;
        n_pri        = r_pri;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = phys(r_head, {1'b0, r_idx} + (AW+1)'(1));
        mem_wdata    = new_entry;
        mem_raddr    = phys(r_head, {1'b0, r_idx});

        case (r_state)
            S_IDLE: begin
                mem_raddr = r_head;
                if (in_accept) begin
                    n_val        = i_item_value;
                    n_pri        = i_priority_req;
                    n_res_entry  = '0;
                    n_res_last   = 1'b1;
                    n_res_status = ST_OK;
                    n_idx        = '0;
                    case (i_kind)
                        KIND_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                                n_state      = S_EMIT;
                            end else if (r_count == '0) begin
                                // First entry goes straight to the head slot.
                                mem_we    = 1'b1;
                                mem_waddr = r_head;
                                mem_wdata = '{value: i_item_value, prio: i_priority_req};
                                n_count   = r_count + CW'(1);
                                n_state   = S_EMIT;
                            end else begin
                                n_idx   = AW'(r_count - CW'(1));
                                n_state = S_INS_RD;
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_UNDERFLOW;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_RM_WAIT;
                            end
                        end
                        KIND_LIST: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_LST_WAIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                n_state = S_INS_CMP;
            end

            // Move a larger entry up one slot, or drop the new one in above it.
            S_INS_CMP: begin
                mem_we = 1'b1;
                if ($signed(mem_rdata.prio) > $signed(r_pri)) begin
                    mem_wdata = mem_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_EMIT;
                end
            end

            // The new entry has the smallest priority and becomes the head.
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_head;
                n_count   = r_count + CW'(1);
                n_state   = S_EMIT;
            end

            S_RM_WAIT: begin
                n_res_entry = mem_rdata;
                n_head      = phys(r_head, (AW+1)'(1));
                n_count     = r_count - CW'(1);
                n_state     = S_EMIT;
            end

            S_LST_RD: begin
                n_state = S_LST_WAIT;
            end

            S_LST_WAIT: begin
                n_res_entry = mem_rdata;
                n_res_last  = ((CW'(r_idx) + CW'(1)) == r_count);
                n_state     = S_EMIT;
            end

            // Hand the pending result to the output register.
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_last   = r_res_last;
                    if (r_res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_LST_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_pri        <= n_pri;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_value    = r_out_entry.value;
    assign o_out_priority = r_out_entry.prio;
    assign o_last         = r_out_last;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sorted priority queue.
// Depends on spq_pkg and sorted_priority_queue_top. It runs a short directed table
// and then random insert, remove and list traffic, and checks every result item.
module tb_top;
    import spq_pkg::*;

    localparam int          CLK_PERIOD    = 12;
    localparam int          QDEPTH        = DEPTH_DEF;
    localparam int          N_RANDOM      = 300;
    localparam int          CALM_ITEMS    = 40;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    // One result item as the block presents it.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic               last_flag;
    } t_reply;

    // One row of the directed table.
    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        bit                 has_fixed;
        logic [1:0]         fixed_status;
    } t_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic [1:0]         i_kind         = KIND_INSERT;
    logic signed [31:0] i_item_value   = 32'sd0;
    logic signed [31:0] i_priority_req = 32'sd0;
    logic               i_out_stall    = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_out_value;
    logic signed [31:0] o_out_priority;
    logic               o_last;

    // Typed-in expectation that travels with the item being offered.
    bit                 drv_has_fixed = 1'b0;
    t_reply             drv_fixed     = '0;

    // Shadow copy of the sorted store.
    logic signed [31:0] shadow_val [QDEPTH];
    logic signed [31:0] shadow_pri [QDEPTH];
    int                 shadow_count = 0;

    t_reply             step_replies [$];
    t_reply             queue_replies [$];
    t_row               stim_table [$];
    int                 fail_count = 0;
    bit                 calm = 1'b0;
    int                 fill = 0;
    int                 stall_left = 0;

    sorted_priority_queue_top #(
        .DEPTH(QDEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_item_value   (i_item_value),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Applies one operation to the shadow store and lists the result items it causes.
    task automatic apply_queue_op(input logic [1:0] kind, input logic signed [31:0] val,
                                  input logic signed [31:0] pri);
        int pos;
        int i;
        step_replies.delete();
        case (kind)
            KIND_INSERT: begin
                if (shadow_count >= QDEPTH) begin
                    step_replies.push_back('{ST_FULL, 32'sd0, 32'sd0, 1'b1});
                end else begin
                    // The new entry goes behind every entry of lower or equal priority.
                    pos = 0;
                    while (pos < shadow_count && shadow_pri[pos] <= pri) pos++;
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_val[i] = shadow_val[i - 1];
                        shadow_pri[i] = shadow_pri[i - 1];
                    end
                    shadow_val[pos] = val;
                    shadow_pri[pos] = pri;
                    shadow_count++;
                    step_replies.push_back('{ST_OK, 32'sd0, 32'sd0, 1'b1});
                end
            end
            KIND_REMOVE: begin
                if (shadow_count == 0) begin
                    step_replies.push_back('{ST_UNDERFLOW, 32'sd0, 32'sd0, 1'b1});
                end else begin
                    step_replies.push_back('{ST_OK, shadow_val[0], shadow_pri[0], 1'b1});
                    for (i = 1; i < shadow_count; i++) begin
                        shadow_val[i - 1] = shadow_val[i];
                        shadow_pri[i - 1] = shadow_pri[i];
                    end
                    shadow_count--;
                end
            end
            KIND_LIST: begin
                if (shadow_count == 0) begin
                    step_replies.push_back('{ST_EMPTY, 32'sd0, 32'sd0, 1'b1});
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        step_replies.push_back('{ST_OK, shadow_val[i], shadow_pri[i],
                                                 (i + 1 == shadow_count)});
                    end
                end
            end
            default: begin
                // The unused kind changes nothing and returns nothing.
            end
        endcase
    endtask

    // Predicts on each accepted item and checks each accepted result item.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                apply_queue_op(i_kind, i_item_value, i_priority_req);
                if (drv_has_fixed) begin
                    queue_replies.push_back(drv_fixed);
                end else begin
                    foreach (step_replies[k]) queue_replies.push_back(step_replies[k]);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_status, o_out_value, o_out_priority, o_last};
                if (queue_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("ERROR: extra result: st %0d val %0d pri %0d last %0b",
                                 got.status, got.value, got.prio, got.last_flag);
                    end
                end else begin
                    want = queue_replies.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("ERROR: st %0d/%0d val %0d/%0d pri %0d/%0d (exp/got)",
                                     want.status, got.status, want.value, got.value,
                                     want.prio, got.prio);
                            $display("       last %0b/%0b (exp/got)",
                                     want.last_flag, got.last_flag);
                        end
                    end
                end
            end
        end
    end

    // Output stall comes in random bursts between free-running stretches.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 9);
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= $urandom_range(0, 29);
        end
    end

    // Offers one item, holds it until accepted and may then idle for a burst.
    task automatic send_item(input logic [1:0] kind, input logic signed [31:0] val,
                             input logic signed [31:0] pri, input bit has_fixed,
                             input logic [1:0] fixed_status);
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_item_value   <= val;
        i_priority_req <= pri;
        drv_has_fixed  <= has_fixed;
        drv_fixed      <= '{fixed_status, 32'sd0, 32'sd0, 1'b1};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (kind == KIND_INSERT && fill < QDEPTH) fill++;
        if (kind == KIND_REMOVE && fill > 0) fill--;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [1:0] kind, input logic signed [31:0] val,
                           input logic signed [31:0] pri, input bit has_fixed,
                           input logic [1:0] fixed_status);
        stim_table.push_back('{kind, val, pri, has_fixed, fixed_status});
    endtask

    // Priorities lean toward a narrow band so that ties are common.
    function automatic logic signed [31:0] pick_priority();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3, 4: return int'($urandom_range(0, 6)) - 3;
            default:    return $urandom;
        endcase
    endfunction

    initial begin
        bit          filling;
        int          n;
        int          roll;
        logic [1:0]  kind;

        // Directed table: empty store, ignored kind, extremes, ties, then fill to full.
        add_row(KIND_LIST,    32'sh5a5a5a5a, 32'sh12345678, 1'b1, ST_EMPTY);
        add_row(KIND_REMOVE,  -32'sd1,       32'sh80000000, 1'b1, ST_UNDERFLOW);
        add_row(KIND_UNUSED,  32'sh7fffffff, 32'sh7fffffff, 1'b0, ST_OK);
        add_row(KIND_INSERT,  32'sh7fffffff, 32'sh7fffffff, 1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sh80000000, 32'sh80000000, 1'b1, ST_OK);
        add_row(KIND_INSERT,  -32'sd1,       32'sd0,        1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd5,        32'sd0,        1'b1, ST_OK);
        add_row(KIND_LIST,    32'sd0,        32'sd0,        1'b0, ST_OK);
        add_row(KIND_REMOVE,  32'sh0f0f0f0f, -32'sd7,       1'b0, ST_OK);
        add_row(KIND_INSERT,  32'sha5a50001, 32'sd3,        1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sh5a5a0002, -32'sd3,       1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd3,        32'sd0,        1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd4,        32'sh7fffffff, 1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd5,        32'sh80000000, 1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd6,        -32'sd1,       1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd7,        32'sd1,        1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd8,        32'sd100,      1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd9,        -32'sd100,     1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd10,       32'sd0,        1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd11,       32'sd3,        1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd12,       32'sh40000000, 1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd13,       32'shbfffffff, 1'b1, ST_OK);
        add_row(KIND_INSERT,  32'sd14,       32'sd2,        1'b1, ST_FULL);
        add_row(KIND_LIST,    32'sd0,        32'sd0,        1'b0, ST_OK);
        add_row(KIND_REMOVE,  32'sd0,        32'sd0,        1'b0, ST_OK);

        // Synchronous reset at the start, then release.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[r]) begin
            send_item(stim_table[r].kind, stim_table[r].value, stim_table[r].prio,
                      stim_table[r].has_fixed, stim_table[r].fixed_status);
        end

        // Random traffic alternates between filling toward full and draining to empty.
        filling = 1'b1;
        n = 0;
        while (n < N_RANDOM) begin
            if (n == N_RANDOM - CALM_ITEMS) calm <= 1'b1;
            if (filling && fill == QDEPTH && $urandom_range(0, 1) == 0) filling = 1'b0;
            else if (!filling && fill == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 4)       kind = KIND_UNUSED;
            else if (roll < 14) kind = KIND_LIST;
            else if (roll < 84) kind = filling ? KIND_INSERT : KIND_REMOVE;
            else                kind = filling ? KIND_REMOVE : KIND_INSERT;
            send_item(kind, ($urandom_range(0, 7) == 0) ? pick_priority() : $urandom,
                      pick_priority(), 1'b0, ST_OK);
            if (kind != KIND_UNUSED) n++;
        end

        // Wait for every expected result, then for stray ones.
        i_in_valid <= 1'b0;
        while (queue_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // A result that never arrived is a failure too.
        if (queue_replies.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_mem.sv
rtl/sorted_priority_queue_top.sv
test/tb_top.sv
